>>> sv/dfd_pkg.sv
// Shared types and constants of the discrete Frechet distance block.
package dfd_pkg;

	// Result fields.
	localparam int DIST_W   = 17;
	localparam int STATUS_W = 2;
	localparam int OUT_DW   = ((DIST_W + 7) / 8) * 8;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	// Bit positions inside the input tuser word.
	localparam int TUSER_REQ_TYPE   = 0;
	localparam int TUSER_STARTS_NEW = 1;
	localparam int IN_TUSER_W       = 2;

	// Request kinds.
	localparam logic REQ_FIRST  = 1'b0;
	localparam logic REQ_SECOND = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_ROOT  = 5'b01000,
		ST_EMIT  = 5'b10000
	} dfd_state_t;

endpackage

>>> sv/dfd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/dfd_sqrt.sv
// Iterative ceiling integer square root, one result bit per cycle.
module dfd_sqrt #(
	parameter int IN_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   value,
	output logic              done,
	output logic [IN_W/2:0]   root
);

	localparam int H  = IN_W / 2;
	localparam int RW = H + 4;
	localparam int NW = $clog2(H + 1);

	logic            busy_q;
	logic            done_q;
	logic [NW-1:0]   cnt_q;
	logic [IN_W-1:0] val_q;
	logic [RW-1:0]   rem_q;
	logic [H-1:0]    root_q;

	logic [RW-1:0]   rem_sh;
	logic [RW-1:0]   trial;
	logic            ge;

	// Bring down the next two bits and try to subtract 4*root + 1.
	assign rem_sh = {rem_q[RW-3:0], val_q[IN_W-1:IN_W-2]};
	assign trial  = RW'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == NW'(H - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(H - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[H-2:0], ge};
		end
	end

	// A nonzero remainder means the floor root falls short of the ceiling.
	assign done = done_q;
	assign root = (H + 1)'(root_q) + (H + 1)'(rem_q != '0);

endmodule

>>> sv/discrete_frechet_distance_top.sv
// Top level of the discrete Frechet distance block: point store, row store and sweep pipeline.
//
//  Channel   | Direction | Payload                                         | Accepted when
//  ----------+-----------+-------------------------------------------------+--------------------
//  s_*       | in        | tdata: point_x, point_y; tuser: req_type,       | s_tvalid && s_tready
//            |           | starts_new; tlast: ends_curve                   |
//  m_*       | out       | tdata: distance; tuser: status                  | m_tvalid && m_tready
//
// A first-curve request is written to the point store as it is accepted. A second-curve
// request against n stored points is handled by the row sweep, which reads one point
// and one row entry per cycle from the two memories. A request that ends the second
// curve then runs the ceiling square root, unless the point store has overflowed, and
// hands the result to the output register.
// Reset is asynchronous and active low; the memories are not cleared, since only entries
// below the stored point count are ever read and those have been written.
// A stalled output register does not block new requests until a further result is due.
module discrete_frechet_distance_top
	import dfd_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// point_x [COORD_BITS-1:0], point_y [2*COORD_BITS-1:COORD_BITS], zero padding above
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_tdata,
	// req_type [0], starts_new [1]
	input  logic [IN_TUSER_W-1:0]                      s_tuser,
	input  logic                                       s_tlast,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// distance [16:0], zero padding above
	output logic [OUT_DW-1:0]                          m_tdata,
	// status [1:0]
	output logic [STATUS_W-1:0]                        m_tuser
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int C   = COORD_BITS;
	localparam int PW  = 2 * COORD_BITS;
	localparam int SQW = 2 * COORD_BITS;
	localparam int D2W = 2 * COORD_BITS + 2;
	localparam int RTW = COORD_BITS + 2;

	dfd_state_t          state_q;
	logic [CW-1:0]       count_q;
	logic                ovf_q;
	logic                row_active_q;
	logic                act_q;
	logic                ends_q;
	logic [AW-1:0]       k_q;
	logic [C-1:0]        qx_q;
	logic [C-1:0]        qy_q;
	logic [DIST_W-1:0]   res_dist_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                m_tvalid_q;
	logic [DIST_W-1:0]   m_dist_q;
	logic [STATUS_W-1:0] m_status_q;

	logic                accept;
	logic                is_second;
	logic                starts;
	logic                issue;
	logic                last_issue;
	logic                drained;
	logic                out_free;

	// Memory ports.
	logic                pt_we;
	logic [AW-1:0]       pt_waddr;
	logic [PW-1:0]       pt_rdata;
	logic [D2W-1:0]      row_rdata;

	// Sweep pipeline.
	logic                v_s1, v_s2, v_s3, v_s4;
	logic                first_s1, first_s2, first_s3, first_s4;
	logic [AW-1:0]       k_s1, k_s2, k_s3, k_s4;
	logic [C-1:0]        dx_s2, dy_s2;
	logic [D2W-1:0]      up_s2, up_s3, up_s4;
	logic [SQW-1:0]      sqx_s3, sqy_s3;
	logic [D2W-1:0]      d2_s4, mdu_s4;
	logic [D2W-1:0]      new_q;

	logic [C:0]          diff_x, diff_y;
	logic [C-1:0]        abs_x, abs_y;
	logic [D2W-1:0]      d2_sum, mdu;
	logic [D2W-1:0]      bmin, best, new_val;

	logic                sq_start;
	logic                sq_done;
	logic [RTW-1:0]      sq_root;

	assign accept    = s_tvalid && s_tready;
	assign is_second = s_tuser[TUSER_REQ_TYPE];
	assign starts    = s_tuser[TUSER_STARTS_NEW];
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	// A starting point always lands at entry 0; otherwise a full store drops it.
	assign pt_we    = accept && (is_second == REQ_FIRST)
	                  && (starts || (count_q < CW'(MAX_POINTS)));
	assign pt_waddr = starts ? '0 : count_q[AW-1:0];

	assign issue      = (state_q == ST_SWEEP);
	assign last_issue = issue && ((CW'(k_q) + CW'(1)) == count_q);
	assign drained    = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign sq_start   = (state_q == ST_DRAIN) && drained && ends_q && !ovf_q;

	dfd_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (s_tdata[PW-1:0]),
		.raddr (k_q),
		.rdata (pt_rdata)
	);

	dfd_ram #(
		.WIDTH (D2W),
		.DEPTH (MAX_POINTS)
	) u_row_ram (
		.clk   (clk),
		.we    (v_s4),
		.waddr (k_s4),
		.wdata (new_val),
		.raddr (k_q),
		.rdata (row_rdata)
	);

	dfd_sqrt #(
		.IN_W (D2W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (new_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Stage 1: absolute coordinate differences against the current second-curve point.
	assign diff_x = {pt_rdata[C-1], pt_rdata[C-1:0]} - {qx_q[C-1], qx_q};
	assign diff_y = {pt_rdata[PW-1], pt_rdata[PW-1:C]} - {qy_q[C-1], qy_q};
	assign abs_x  = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
	assign abs_y  = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];

	// Stage 3: squared distance, and the smaller of the diagonal and upper neighbors.
	// The diagonal is the old row value of the previous point, one stage ahead.
	assign d2_sum = D2W'(sqx_s3) + D2W'(sqy_s3);
	assign mdu    = first_s3 ? up_s3 : ((up_s4 < up_s3) ? up_s4 : up_s3);

	// Stage 4: the left neighbor is the value just written for the previous point.
	// On a fresh second curve only the left neighbor counts, and the first cell is
	// the squared distance alone.
	always_comb begin
		bmin = (mdu_s4 < new_q) ? mdu_s4 : new_q;
		if (first_s4) begin
			best = act_q ? mdu_s4 : '0;
		end else begin
			best = act_q ? bmin : new_q;
		end
		new_val = (best > d2_s4) ? best : d2_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		k_s1     <= k_q;
		first_s1 <= (k_q == '0);
		k_s2     <= k_s1;
		first_s2 <= first_s1;
		dx_s2    <= abs_x;
		dy_s2    <= abs_y;
		up_s2    <= row_rdata;
		k_s3     <= k_s2;
		first_s3 <= first_s2;
		sqx_s3   <= SQW'(dx_s2) * SQW'(dx_s2);
		sqy_s3   <= SQW'(dy_s2) * SQW'(dy_s2);
		up_s3    <= up_s2;
		k_s4     <= k_s3;
		first_s4 <= first_s3;
		d2_s4    <= d2_sum;
		mdu_s4   <= mdu;
		up_s4    <= up_s3;
		if (v_s4) begin
			new_q <= new_val;
		end
	end

	// Request sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			row_active_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// The output register is loaded from the emit state and emptied by a handshake.
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_second == REQ_FIRST) begin
							row_active_q <= 1'b0;
							if (starts) begin
								count_q <= CW'(1);
								ovf_q   <= 1'b0;
							end else if (count_q < CW'(MAX_POINTS)) begin
								count_q <= count_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (count_q == '0) begin
							row_active_q <= 1'b0;
							if (s_tlast) begin
								state_q <= ST_EMIT;
							end
						end else begin
							row_active_q <= !s_tlast;
							state_q      <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						if (!ends_q) begin
							state_q <= ST_IDLE;
						end else if (ovf_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-request payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q   <= s_tdata[C-1:0];
			qy_q   <= s_tdata[PW-1:C];
			ends_q <= s_tlast;
			act_q  <= row_active_q;
			k_q    <= '0;
			res_dist_q   <= '0;
			res_status_q <= STATUS_EMPTY;
		end else if (issue) begin
			k_q <= k_q + AW'(1);
		end
		if ((state_q == ST_DRAIN) && drained) begin
			res_dist_q   <= '0;
			res_status_q <= STATUS_OVERFLOW;
		end
		if ((state_q == ST_ROOT) && sq_done) begin
			res_dist_q   <= DIST_W'(sq_root);
			res_status_q <= STATUS_OK;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			m_dist_q   <= res_dist_q;
			m_status_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'(m_dist_q);
	assign m_tuser  = m_status_q;

`ifndef SYNTH
	// No row update may be in flight while a new request can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("row sweep still in flight while ready");

	// Row store writes come only from the sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("row store written outside a sweep");

	// The point count never passes the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	// The square root finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_ROOT))
		else $error("square root result outside root state");

	// A result is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_free) |=> (state_q == ST_EMIT))
		else $error("result left emit state while output busy");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for the discrete Frechet distance block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfd_pkg::*;

	localparam int MAX_PTS     = 1024;
	localparam int CB          = 16;
	localparam int IN_DW       = ((2 * CB + 7) / 8) * 8;
	localparam int RANDOM_REQS = 550;
	localparam int SETTLE_CYC  = 1200;
	localparam int CYCLE_LIMIT = 800000;

	// One point request as it is queued for the sender.
	typedef struct packed {
		logic                 hold;
		logic                 ends_curve;
		logic                 starts_new;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] x;
		logic                 req_type;
	} point_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   distance;
	} frechet_result_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  s_tvalid   = 1'b0;
	logic                  s_tready;
	logic [IN_DW-1:0]      s_tdata    = '0;
	logic [IN_TUSER_W-1:0] s_tuser    = '0;
	logic                  s_tlast    = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready   = 1'b0;
	logic [OUT_DW-1:0]     m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	point_req_t      pending_reqs [$];
	frechet_result_t due_results [$];

	int  reqs_issued   = 0;
	int  reqs_accepted = 0;
	int  mismatches    = 0;
	int  cycle_count   = 0;
	int  send_gap      = 0;
	int  calm_send     = 0;
	int  stall_left    = 0;
	int  calm_recv     = 0;
	bit  sender_idle   = 1'b0;

	// Predictor state: stored first curve and the current coupling row.
	logic signed [CB-1:0] curve_x [MAX_PTS];
	logic signed [CB-1:0] curve_y [MAX_PTS];
	longint unsigned      coupling_row [MAX_PTS];
	int                   stored_pts     = 0;
	bit                   row_live       = 1'b0;
	bit                   store_overflow = 1'b0;

	discrete_frechet_distance_top #(
		.MAX_POINTS(MAX_PTS),
		.COORD_BITS(CB)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic flag_error(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic longint unsigned sq_gap(input logic signed [CB-1:0] ax, ay, bx, by);
		longint dx, dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// Smallest r with r*r >= v, cut to the width of the distance field.
	function automatic logic [DIST_W-1:0] ceil_root(input longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 18; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		if (r * r < v)
			r = r + 1;
		return r[DIST_W-1:0];
	endfunction

	// Advances the predicted state by one accepted request and queues any result it causes.
	task automatic frechet_step(input point_req_t rq);
		longint unsigned diag, up, best, d;
		frechet_result_t res;
		if (rq.req_type == REQ_FIRST) begin
			if (rq.starts_new) begin
				stored_pts     = 0;
				store_overflow = 1'b0;
			end
			row_live = 1'b0;
			if (stored_pts < MAX_PTS) begin
				curve_x[stored_pts] = rq.x;
				curve_y[stored_pts] = rq.y;
				stored_pts++;
			end else begin
				store_overflow = 1'b1;
			end
		end else if (stored_pts == 0) begin
			// Nothing to compare against: only the end of the curve reports.
			row_live = 1'b0;
			if (rq.ends_curve) begin
				res.distance = '0;
				res.status   = STATUS_EMPTY;
				due_results.push_back(res);
			end
		end else begin
			if (!row_live) begin
				coupling_row[0] = sq_gap(curve_x[0], curve_y[0], rq.x, rq.y);
				for (int k = 1; k < stored_pts; k++) begin
					d = sq_gap(curve_x[k], curve_y[k], rq.x, rq.y);
					coupling_row[k] = (coupling_row[k-1] > d) ? coupling_row[k-1] : d;
				end
			end else begin
				diag = coupling_row[0];
				d = sq_gap(curve_x[0], curve_y[0], rq.x, rq.y);
				if (d > coupling_row[0])
					coupling_row[0] = d;
				for (int k = 1; k < stored_pts; k++) begin
					up   = coupling_row[k];
					best = (diag < coupling_row[k-1]) ? diag : coupling_row[k-1];
					if (up < best)
						best = up;
					diag = up;
					d = sq_gap(curve_x[k], curve_y[k], rq.x, rq.y);
					coupling_row[k] = (best > d) ? best : d;
				end
			end
			row_live = 1'b1;
			if (rq.ends_curve) begin
				row_live = 1'b0;
				if (store_overflow) begin
					res.distance = '0;
					res.status   = STATUS_OVERFLOW;
				end else begin
					res.distance = ceil_root(coupling_row[stored_pts-1]);
					res.status   = STATUS_OK;
				end
				due_results.push_back(res);
			end
		end
	endtask

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return $urandom_range(1, 2);
		else if (pick < 90)
			return $urandom_range(3, 8);
		else
			return $urandom_range(20, 80);
	endfunction

	// Sender: presents the next request once the previous one has been taken.
	always @(negedge clk) begin : drive_points
		point_req_t            nxt;
		logic [IN_TUSER_W-1:0] tu;
		if (arst_n && reqs_accepted == reqs_issued) begin
			if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() == 0 ||
			             (pending_reqs[0].hold && due_results.size() != 0)) begin
				// A held request waits until every outstanding result has come back.
				s_tvalid <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				tu = '0;
				tu[TUSER_REQ_TYPE]   = nxt.req_type;
				tu[TUSER_STARTS_NEW] = nxt.starts_new;
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt.y, nxt.x};
				s_tuser  <= tu;
				s_tlast  <= nxt.ends_curve;
				reqs_issued++;
				if (calm_send != 0) begin
					calm_send--;
					send_gap = 0;
				end else begin
					send_gap = $urandom_range(0, 1) ? 0 : pause_len();
					if ($urandom_range(0, 99) == 0)
						calm_send = $urandom_range(30, 150);
				end
			end
		end
		sender_idle = (pending_reqs.size() == 0 && reqs_accepted == reqs_issued);
	end

	// Receiver: random back-pressure with stretches of none.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (calm_recv != 0) begin
				calm_recv--;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = pause_len();
				if ($urandom_range(0, 15) == 0)
					calm_recv = $urandom_range(50, 300);
			end
		end
	end

	// Results are checked before the request of the same edge is predicted,
	// so a new expectation can never be matched against an older result.
	always @(posedge clk) begin : watch_bus
		point_req_t      got;
		frechet_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("unexpected result distance %0d status %0d",
					m_tdata[DIST_W-1:0], m_tuser));
			end else begin
				want = due_results.pop_front();
				if (m_tdata[DIST_W-1:0] !== want.distance)
					flag_error($sformatf("distance %0d, expected %0d",
						m_tdata[DIST_W-1:0], want.distance));
				if (m_tuser !== want.status)
					flag_error($sformatf("status %0d, expected %0d", m_tuser, want.status));
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			got.req_type   = s_tuser[TUSER_REQ_TYPE];
			got.starts_new = s_tuser[TUSER_STARTS_NEW];
			got.ends_curve = s_tlast;
			got.x          = s_tdata[CB-1:0];
			got.y          = s_tdata[2*CB-1:CB];
			got.hold       = 1'b0;
			frechet_step(got);
			reqs_accepted++;
		end
	end

	task automatic add_req(input logic rt, input logic [CB-1:0] x, y,
	                       input logic sn, ec, hold);
		point_req_t rq;
		rq.req_type   = rt;
		rq.x          = x;
		rq.y          = y;
		rq.starts_new = sn;
		rq.ends_curve = ec;
		rq.hold       = hold;
		pending_reqs.push_back(rq);
	endtask

	// Coordinates cluster around a base point, with extremes and wild values mixed in.
	function automatic logic [CB-1:0] pick_coord(input logic [CB-1:0] base);
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return CB'($urandom);
			default: return base + 16'($urandom_range(0, 80)) - 16'd40;
		endcase
	endfunction

	initial begin : stimulus
		int          n, m, target;
		logic [CB-1:0] bx, by;
		bit          hold;

		// Second-curve requests against an empty store: ignored, then an empty-store result.
		add_req(REQ_SECOND, 16'd1, 16'd2, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, -16'sd5, 16'd7, 1'b0, 1'b1, 1'b0);
		// Extreme corners; a tlast on a first-curve request is ignored.
		add_req(REQ_FIRST, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0);
		add_req(REQ_FIRST, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b0);
		add_req(REQ_FIRST, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
		// Largest distance; starts_new on a second-curve request is ignored.
		add_req(REQ_SECOND, 16'h7fff, 16'h7fff, 1'b1, 1'b1, 1'b0);
		add_req(REQ_SECOND, 16'h8000, 16'h7fff, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'h7fff, 16'h8000, 1'b0, 1'b1, 1'b0);
		// Single stored point: zero distance, then a distance of five.
		add_req(REQ_FIRST, 16'd100, -16'sd200, 1'b1, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd100, -16'sd200, 1'b0, 1'b1, 1'b0);
		add_req(REQ_SECOND, 16'd103, -16'sd196, 1'b0, 1'b1, 1'b0);
		// A first-curve request in the middle of a second curve abandons it.
		add_req(REQ_FIRST, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		add_req(REQ_FIRST, 16'd10, 16'd0, 1'b0, 1'b0, 1'b0);
		add_req(REQ_FIRST, 16'd20, 16'd0, 1'b0, 1'b0, 1'b0);
		add_req(REQ_FIRST, 16'd30, 16'd0, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd0, 16'd1, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd20, 16'd1, 1'b0, 1'b0, 1'b0);
		add_req(REQ_FIRST, 16'd40, 16'd0, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd0, 16'd3, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd40, 16'd3, 1'b0, 1'b1, 1'b0);
		// After a result the next point starts a fresh second curve.
		add_req(REQ_SECOND, -16'sd1, -16'sd1, 1'b0, 1'b1, 1'b0);

		// Random part: mostly complete curve pairs, some noise.
		target = pending_reqs.size() + RANDOM_REQS;
		while (pending_reqs.size() < target) begin
			if ($urandom_range(0, 99) < 85) begin
				n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
				bx   = CB'($urandom);
				by   = CB'($urandom);
				hold = ($urandom_range(0, 9) == 0);
				for (int i = 0; i < n; i++)
					add_req(REQ_FIRST, pick_coord(bx), pick_coord(by), i == 0,
						$urandom_range(0, 3) == 0, hold && i == 0);
				repeat ($urandom_range(1, 3)) begin
					m = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
					for (int j = 0; j < m; j++)
						add_req(REQ_SECOND, pick_coord(bx), pick_coord(by),
							$urandom_range(0, 3) == 0, j == m - 1, 1'b0);
				end
			end else begin
				repeat ($urandom_range(1, 4))
					add_req(1'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
						$urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0, 1'b0);
			end
		end

		// A fresh first curve that goes out only once every result has come back.
		add_req(REQ_FIRST, 16'd5, 16'd5, 1'b1, 1'b0, 1'b1);
		add_req(REQ_FIRST, 16'd9, 16'd8, 1'b0, 1'b0, 1'b0);
		add_req(REQ_SECOND, 16'd6, 16'd6, 1'b0, 1'b1, 1'b0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Let every request go out, every result come back, and any late sweep finish.
		@(posedge clk);
		while (!sender_idle)
			@(posedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
